/* design/sde_pkg.sv */
// Shared types and constants for the sorted dictionary index encoder.
// No dependencies; imported by the top level and sde_engine.
`timescale 1ns / 1ps
package sde_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int DATA_W           = 32;
	localparam int DCOUNT_W         = 11;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_ELEM  = 1'b1;

	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;

	localparam logic [31:0] WC8_LIMIT  = 32'd256;
	localparam logic [31:0] WC16_LIMIT = 32'd65536;

	typedef struct packed {
		logic              req_type;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                kind;
		logic [DATA_W-1:0]   data;
		logic [DCOUNT_W-1:0] distinct_count;
		logic [1:0]          width_code;
		logic                overflow;
		logic                last;
	} res_t;

endpackage

/* design/sorted_dictionary_index_encoder.sv */
// Sorted dictionary index encoder: top level with config register and both RAMs.
// Depends on sde_pkg, sde_ram and sde_engine.
//
// Add words store a value and insert it into a sorted, duplicate-free table;
// readout words each return one result, the table in ascending order and then
// every stored value's table index in arrival order (raw values with the
// transform off); a readout of an empty block returns none. One word is
// handled at a time and req_stall stays high until it is done. The single
// compare unit and the one-read-port table RAM set the timing: each binary
// search takes k <= ceil(log2(n+1)) steps (n = distinct count), a new value
// then shifts every larger table entry up one slot, and an indexed element
// readout runs one such search. A dropped or ignored add gives no result. A
// result also waits while the previous one is held by res_stall.
`timescale 1ns / 1ps
module sorted_dictionary_index_encoder #(
	parameter int MAX_ELEMENTS = sde_pkg::MAX_ELEMENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sde_pkg::req_t req_word,
	output logic          res_valid,
	input  logic          res_stall,
	output sde_pkg::res_t res_word,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);
	import sde_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);

	logic              te_q;
	logic              elem_we, tab_we;
	logic [AW-1:0]     elem_waddr, elem_raddr, tab_waddr, tab_raddr;
	logic [DATA_W-1:0] elem_wdata, elem_rdata, tab_wdata, tab_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			te_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			te_q <= cfg_data;
		end
	end

	sde_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (elem_wdata),
		.raddr (elem_raddr),
		.rdata (elem_rdata)
	);

	sde_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	sde_engine #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.transform_enable (te_q),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.req_word         (req_word),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.res_word         (res_word),
		.elem_we          (elem_we),
		.elem_waddr       (elem_waddr),
		.elem_wdata       (elem_wdata),
		.elem_raddr       (elem_raddr),
		.elem_rdata       (elem_rdata),
		.tab_we           (tab_we),
		.tab_waddr        (tab_waddr),
		.tab_wdata        (tab_wdata),
		.tab_raddr        (tab_raddr),
		.tab_rdata        (tab_rdata)
	);
endmodule

/* design/sde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* design/sde_engine.sv */
// Sequencer for the encoder: one shared compare unit does the binary searches,
// insertion shifts move one entry per S_SHRD/S_SHWR pass. Depends on sde_pkg.
`timescale 1ns / 1ps
module sde_engine #(
	parameter int MAX_ELEMENTS = sde_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            transform_enable,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  sde_pkg::req_t                   req_word,
	output logic                            res_valid,
	input  logic                            res_stall,
	output sde_pkg::res_t                   res_word,
	output logic                            elem_we,
	output logic [$clog2(MAX_ELEMENTS)-1:0] elem_waddr,
	output logic [sde_pkg::DATA_W-1:0]      elem_wdata,
	output logic [$clog2(MAX_ELEMENTS)-1:0] elem_raddr,
	input  logic [sde_pkg::DATA_W-1:0]      elem_rdata,
	output logic                            tab_we,
	output logic [$clog2(MAX_ELEMENTS)-1:0] tab_waddr,
	output logic [sde_pkg::DATA_W-1:0]      tab_wdata,
	output logic [$clog2(MAX_ELEMENTS)-1:0] tab_raddr,
	input  logic [sde_pkg::DATA_W-1:0]      tab_rdata
);
	import sde_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_CMP, S_CHK, S_SHRD, S_SHWR, S_TABRD, S_ELRD, S_EMIT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     elem_cnt_q, tab_cnt_q, pos_q, lo_q, hi_q, mid_q, idx_q;
	logic              phase_q, ovf_q, lookup_q, last_q, kind_q;
	logic [DATA_W-1:0] key_q, data_q;
	logic              res_valid_q;
	res_t              res_word_q;

	logic              accept, out_free, rd_table;
	logic [CW:0]       mid_sum;
	logic [CW-1:0]     mid_w, pos_b, pos_c, pos_inc;
	logic [1:0]        wc;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !(res_valid_q && res_stall);
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	assign mid_sum  = ((CW+1)'(lo_q) + (CW+1)'(hi_q)) >> 1;
	assign mid_w    = CW'(mid_sum);
	assign rd_table = !phase_q && transform_enable && (pos_q < tab_cnt_q);
	// transform off in table phase restarts at the first element
	assign pos_b    = phase_q ? pos_q : '0;
	assign pos_c    = (pos_b >= elem_cnt_q) ? elem_cnt_q - 1'b1 : pos_b;
	assign pos_inc  = pos_q + 1'b1;

	always_comb begin
		if (!transform_enable) begin
			wc = WC_32;
		end else if (32'(tab_cnt_q) < WC8_LIMIT) begin
			wc = WC_8;
		end else if (32'(tab_cnt_q) < WC16_LIMIT) begin
			wc = WC_16;
		end else begin
			wc = WC_32;
		end
	end

	always_comb begin
		elem_we    = 1'b0;
		elem_waddr = elem_cnt_q[AW-1:0];
		elem_wdata = req_word.value;
		elem_raddr = pos_c[AW-1:0];
		tab_we     = 1'b0;
		tab_waddr  = idx_q[AW-1:0];
		tab_wdata  = tab_rdata;
		tab_raddr  = pos_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				elem_we = accept && req_word.req_type == REQ_ADD && !phase_q
				          && pos_q == '0 && elem_cnt_q != MAX_CNT;
			end
			S_SRCH: begin
				tab_raddr = (lo_q < hi_q) ? mid_w[AW-1:0] : lo_q[AW-1:0];
			end
			S_SHRD: begin
				tab_raddr = AW'(idx_q - 1'b1);
				if (!(idx_q > lo_q)) begin
					tab_we    = 1'b1;
					tab_waddr = lo_q[AW-1:0];
					tab_wdata = key_q;
				end
			end
			S_SHWR: begin
				tab_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			elem_cnt_q  <= '0;
			tab_cnt_q   <= '0;
			pos_q       <= '0;
			phase_q     <= 1'b0;
			ovf_q       <= 1'b0;
			lookup_q    <= 1'b0;
			last_q      <= 1'b0;
			kind_q      <= KIND_TABLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_EMIT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && req_word.req_type == REQ_ADD) begin
						// adds are ignored once readout has begun
						if (!phase_q && pos_q == '0) begin
							if (elem_cnt_q == MAX_CNT) begin
								ovf_q <= 1'b1;
							end else begin
								elem_cnt_q <= elem_cnt_q + 1'b1;
								key_q      <= req_word.value;
								lo_q       <= '0;
								hi_q       <= tab_cnt_q;
								lookup_q   <= 1'b0;
								state_q    <= S_SRCH;
							end
						end
					end else if (accept && elem_cnt_q != '0) begin
						if (rd_table) begin
							if (pos_inc >= tab_cnt_q) begin
								phase_q <= 1'b1;
								pos_q   <= '0;
							end else begin
								pos_q <= pos_inc;
							end
							state_q <= S_TABRD;
						end else begin
							phase_q <= 1'b1;
							pos_q   <= pos_c + 1'b1;
							last_q  <= (pos_c + 1'b1) >= elem_cnt_q;
							state_q <= S_ELRD;
						end
					end
				end
				S_TABRD: begin
					kind_q  <= KIND_TABLE;
					data_q  <= tab_rdata;
					last_q  <= 1'b0;
					state_q <= S_EMIT;
				end
				S_ELRD: begin
					kind_q <= KIND_ELEM;
					if (transform_enable) begin
						key_q    <= elem_rdata;
						lo_q     <= '0;
						hi_q     <= tab_cnt_q;
						lookup_q <= 1'b1;
						state_q  <= S_SRCH;
					end else begin
						data_q  <= elem_rdata;
						state_q <= S_EMIT;
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_w;
						state_q <= S_CMP;
					end else if (lookup_q) begin
						data_q  <= DATA_W'(lo_q);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CMP: begin
					if (tab_rdata < key_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH;
				end
				S_CHK: begin
					if (lo_q < tab_cnt_q && tab_rdata == key_q) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= tab_cnt_q;
						state_q <= S_SHRD;
					end
				end
				S_SHRD: begin
					if (idx_q > lo_q) begin
						state_q <= S_SHWR;
					end else begin
						tab_cnt_q <= tab_cnt_q + 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_SHWR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= S_SHRD;
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid_q                <= 1'b1;
						res_word_q.kind           <= kind_q;
						res_word_q.data           <= data_q;
						res_word_q.distinct_count <= DCOUNT_W'(tab_cnt_q);
						res_word_q.width_code     <= wc;
						res_word_q.overflow       <= ovf_q;
						res_word_q.last           <= last_q;
						if (last_q) begin
							elem_cnt_q <= '0;
							tab_cnt_q  <= '0;
							pos_q      <= '0;
							phase_q    <= 1'b0;
							ovf_q      <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_tab_le_elem: assert property (@(posedge clk) disable iff (!arst_n)
		tab_cnt_q <= elem_cnt_q) else $error("table larger than element count");

	a_elem_cap: assert property (@(posedge clk) disable iff (!arst_n)
		elem_cnt_q <= MAX_CNT) else $error("element count past capacity");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (lo_q <= hi_q && hi_q <= tab_cnt_q))
		else $error("search bounds crossed");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && last_q) |=> (elem_cnt_q == '0 && !phase_q))
		else $error("block not cleared after last word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !out_free) |=> (state_q == S_EMIT))
		else $error("result lost while output stalled");
endmodule

/* test/tb_sorted_dictionary_index_encoder.sv */
// Self-checking testbench for the sorted dictionary index encoder.
// Depends on sde_pkg and sorted_dictionary_index_encoder; a scoreboard class predicts results.
`timescale 1ns / 1ps
module tb_sorted_dictionary_index_encoder;
	import sde_pkg::*;

	localparam int CAPACITY  = MAX_ELEMENTS_DEF;
	localparam int IDLE_LIMIT = 20000;

	class dict_scoreboard;
		int unsigned capacity;
		bit          enable;
		bit [31:0]   elems[$];
		bit [31:0]   dict[$];
		int unsigned pos;
		bit          elem_phase;
		bit          ovf;
		res_t        pending[$];
		int          errors;
		int          checked;

		function new(int unsigned cap);
			capacity = cap;
			enable   = 1'b1;
		endfunction

		// first table slot not below v
		function int unsigned slot_of(bit [31:0] v);
			int unsigned lo, hi, mid;
			lo = 0;
			hi = dict.size();
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (dict[mid] < v) lo = mid + 1;
				else hi = mid;
			end
			return lo;
		endfunction

		function bit in_readout();
			return elem_phase || pos != 0;
		endfunction

		function void note(req_t w);
			res_t        r;
			int unsigned p;
			if (w.req_type == REQ_ADD) begin
				if (in_readout()) return;
				if (elems.size() >= capacity) begin
					ovf = 1'b1;
					return;
				end
				elems.insert(elems.size(), w.value);
				p = slot_of(w.value);
				if (!(p < dict.size() && dict[p] == w.value)) dict.insert(p, w.value);
				return;
			end
			if (elems.size() == 0) return;
			if (!elem_phase && !enable) begin
				elem_phase = 1'b1;
				pos = 0;
			end
			r.last = 1'b0;
			if (!elem_phase && pos < dict.size()) begin
				r.kind = KIND_TABLE;
				r.data = dict[pos];
				pos++;
				if (pos >= dict.size()) begin
					elem_phase = 1'b1;
					pos = 0;
				end
			end else begin
				elem_phase = 1'b1;
				if (pos >= elems.size()) pos = elems.size() - 1;
				r.kind = KIND_ELEM;
				r.data = enable ? 32'(slot_of(elems[pos])) : elems[pos];
				pos++;
				if (pos >= elems.size()) r.last = 1'b1;
			end
			r.distinct_count = DCOUNT_W'(dict.size());
			if (!enable) r.width_code = WC_32;
			else if (dict.size() < WC8_LIMIT) r.width_code = WC_8;
			else if (dict.size() < WC16_LIMIT) r.width_code = WC_16;
			else r.width_code = WC_32;
			r.overflow = ovf;
			pending.insert(pending.size(), r);
			if (r.last) begin
				elems.delete();
				dict.delete();
				pos = 0;
				elem_phase = 1'b0;
				ovf = 1'b0;
			end
		endfunction

		function void cmp(string field, logic [31:0] e, logic [31:0] g);
			if (g !== e) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, g);
				errors++;
			end
		endfunction

		function void check(res_t g);
			res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, g);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			cmp("kind", e.kind, g.kind);
			cmp("data", e.data, g.data);
			cmp("distinct_count", e.distinct_count, g.distinct_count);
			cmp("width_code", e.width_code, g.width_code);
			cmp("overflow", e.overflow, g.overflow);
			cmp("last", e.last, g.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	dict_scoreboard sb = new(CAPACITY);
	bit calm;
	bit hold_request;
	int words_sent;
	int blocks_done;
	int idle_cycles;

	always #10 clk = ~clk;

	sorted_dictionary_index_encoder #(.MAX_ELEMENTS(CAPACITY)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		int stall_left;
		int hold_left;
		if (res_valid && !res_stall) sb.check(res_word);
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			res_stall <= 1'b0;
			stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired, no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_word(input logic kind_req, input logic [31:0] v);
		int g;
		req_t w;
		w.req_type = kind_req;
		w.value    = v;
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (req_stall);
		sb.note(w);
		words_sent++;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// only called right after a word that yields a result, so the block is idle once drained
	task automatic write_enable(input bit v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.enable = v;
	endtask

	function automatic logic [31:0] pick_value(int style);
		case (style)
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h0;
					1: return 32'hFFFF_FFFF;
					default: return $urandom_range(0, 7);
				endcase
			end
			default: return $urandom_range(100, 102);
		endcase
	endfunction

	// one block: n adds then readout until the last word, with noise
	task automatic run_block(input int n, input int style);
		if ($urandom_range(0, 9) == 0) send_word(REQ_READ, $urandom());
		repeat (n) send_word(REQ_ADD, pick_value(style));
		while (sb.elems.size() != 0) begin
			if (sb.in_readout() && $urandom_range(0, 9) == 0)
				send_word(REQ_ADD, $urandom());
			send_word(REQ_READ, $urandom());
			if (sb.elems.size() != 0 && $urandom_range(0, 19) == 0)
				write_enable($urandom_range(0, 1));
		end
		blocks_done++;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty readout, field extremes, a duplicate, an add ignored mid-readout, toggle mid-readout
		send_word(REQ_READ, 32'hFFFF_FFFF);
		send_word(REQ_ADD, 32'hFFFF_FFFF);
		send_word(REQ_ADD, 32'h0);
		send_word(REQ_ADD, 32'hFFFF_FFFF);
		send_word(REQ_ADD, 32'h8000_0000);
		send_word(REQ_ADD, 32'h1);
		send_word(REQ_ADD, 32'hAAAA_AAAA);
		send_word(REQ_ADD, 32'h5555_5555);
		repeat (3) send_word(REQ_READ, 32'h0);
		send_word(REQ_ADD, 32'h1234_5678);
		repeat (5) send_word(REQ_READ, 32'h0);
		write_enable(1'b0);
		repeat (2) send_word(REQ_READ, 32'h0);
		write_enable(1'b1);
		while (sb.elems.size() != 0) send_word(REQ_READ, 32'h0);

		// transform off from the start of a block
		write_enable(1'b0);
		run_block(3, 1);
		write_enable(1'b1);

		hold_request = 1'b1;
		run_block(8, 0);

		while (words_sent < 700) begin
			write_enable($urandom_range(0, 3) != 0);
			calm = ($urandom_range(0, 5) == 0);
			run_block($urandom_range(1, 12), $urandom_range(0, 2));
		end
		calm = 1'b0;

		drain();
		repeat (50) @(posedge clk);
		sb.errors += sb.pending.size();
		if (sb.pending.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending.size());
		$display("Sent %0d request words over %0d blocks; %0d results checked.",
			words_sent, blocks_done, sb.checked);
		$display("Covered empty readouts, duplicates, ignored adds and mid-readout toggles.");
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
